>>> design/eptmr_pkg.sv
package eptmr_pkg;

  // Function codes of an input request.
  localparam logic [1:0] FUNC_TRIGGER = 2'd0;
  localparam logic [1:0] FUNC_EDGE    = 2'd1;
  localparam logic [1:0] FUNC_TICK    = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_BOTTOM = 2'd0;
  localparam logic [1:0] CFG_TOP    = 2'd1;
  localparam logic [1:0] CFG_MODE   = 2'd2;

  // Capture phases.
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_ARMED = 2'd1;
  localparam logic [1:0] PH_WAIT  = 2'd2;

  // Report kinds.
  localparam logic REPORT_DIST = 1'b0;
  localparam logic REPORT_PCT  = 1'b1;

  // Report modes.
  localparam logic MODE_DIST = 1'b0;

  // Scaling constants: distance is measurement * 34 / 25.
  localparam logic [5:0]  DIST_MUL     = 6'd34;
  localparam logic [15:0] DIST_DIV     = 16'd25;
  localparam logic [13:0] PCT_SCALE    = 14'd10000;
  localparam logic [15:0] CHANGE_LIMIT = 16'd5;

  // Shared divider: dividend width and two quotient bits per cycle.
  localparam int DIVIDEND_W = 30;
  localparam int DIV_STEPS  = DIVIDEND_W / 2;
  localparam int STEP_W     = 4;

  // Sequencer states.
  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_SCAN    = 7'b0000010,
    S_MEAN    = 7'b0000100,
    S_CHECK   = 7'b0001000,
    S_DIV     = 7'b0010000,
    S_PCT_MUL = 7'b0100000,
    S_OUT     = 7'b1000000
  } state_t;

endpackage

>>> design/echo_pulse_trimmed_mean_ranger_core.sv
// Ultrasonic echo ranger. A trigger request arms capture, the next echo edge stamps the
// pulse start and the one after it gives the pulse width. Every fourth width, the widths
// are scanned one per cycle, the largest and smallest are dropped and the other two
// averaged, and if the new measurement moved by more than 5 counts a report is made;
// a tick request reports without that check. In percent mode a report is made only when
// the distance lies strictly between the bottom and top levels. Distance and percent
// values come from one shared restoring divider that retires two quotient bits per cycle.
// A percent report adds a multiply state and a second division. Input is stalled while
// an item is being worked on; the output register lets the next request enter while a
// report waits.
module echo_pulse_trimmed_mean_ranger_core #(
  parameter int TIMER_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration write port.
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // Input request channel.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  func,
  input  logic [15:0] capture_time,
  // Report channel.
  output logic        out_valid,
  input  logic        out_stall,
  output logic        report_kind,
  output logic [15:0] report_value
);

  import eptmr_pkg::*;

  // Width differences keep only the timer's bits, at most sixteen.
  localparam int          DIFF_BITS = (TIMER_WIDTH < 16) ? TIMER_WIDTH : 16;
  localparam logic [15:0] DIFF_MASK = 16'((17'd1 << DIFF_BITS) - 17'd1);

  state_t      state;
  logic [15:0] bottom_level;
  logic [15:0] top_level;
  logic        report_mode;
  logic [1:0]  capture_phase;
  logic [15:0] start_stamp;
  logic [15:0] pulse_widths [4];
  logic [1:0]  sample_slot;
  logic [15:0] measurement;
  logic [15:0] last_reported;

  // Scan accumulators.
  logic [1:0]  scan_idx;
  logic [17:0] scan_sum;
  logic [15:0] scan_max;
  logic [15:0] scan_min;

  // Divider registers.
  logic [DIVIDEND_W-1:0] quo;
  logic [15:0]           rem;
  logic [15:0]           divisor;
  logic [STEP_W-1:0]     div_count;
  logic                  pct_pass;
  logic [15:0]           dist_keep;

  logic [15:0] width_raw;
  logic [15:0] width_val;
  logic [15:0] scan_word;
  logic [17:0] trim_sum;
  logic [15:0] delta;
  logic [21:0] dist_prod;
  logic [15:0] dist_off;
  logic [29:0] pct_prod;
  logic [16:0] r1;
  logic [16:0] r1s;
  logic [16:0] r2;
  logic [16:0] r2s;
  logic        ge1;
  logic        ge2;
  logic [DIVIDEND_W-1:0] quo_step;
  logic [15:0]           dist_sat;
  logic                  in_range;
  logic                  out_free;
  logic                  res_kind;
  logic [15:0]           res_value;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  // Pulse width and the scan's current entry.
  assign width_raw = capture_time - start_stamp;
  assign width_val = width_raw & DIFF_MASK;
  assign scan_word = pulse_widths[scan_idx];

  // Dropping one maximum and one minimum leaves the middle pair.
  assign trim_sum = scan_sum - {2'd0, scan_max} - {2'd0, scan_min};

  // Change size against the last change report.
  assign delta = (measurement > last_reported) ? (measurement - last_reported)
                                               : (last_reported - measurement);

  // Products feeding the divider.
  assign dist_prod = {6'd0, measurement} * {16'd0, DIST_MUL};
  assign dist_off  = dist_keep - bottom_level;
  assign pct_prod  = {14'd0, dist_off} * {16'd0, PCT_SCALE};

  // Two restoring division steps per cycle.
  always_comb begin
    r1       = {rem, quo[DIVIDEND_W-1]};
    ge1      = (r1 >= {1'b0, divisor});
    r1s      = ge1 ? (r1 - {1'b0, divisor}) : r1;
    r2       = {r1s[15:0], quo[DIVIDEND_W-2]};
    ge2      = (r2 >= {1'b0, divisor});
    r2s      = ge2 ? (r2 - {1'b0, divisor}) : r2;
    quo_step = {quo[DIVIDEND_W-3:0], ge1, ge2};
  end

  // Distance saturates at the top of sixteen bits.
  assign dist_sat = (|quo_step[DIVIDEND_W-1:16]) ? 16'hFFFF : quo_step[15:0];
  assign in_range = (dist_sat > bottom_level) && (dist_sat < top_level);

  // Sequencer, capture state and the shared divider.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      bottom_level  <= 16'd0;
      top_level     <= 16'hFFFF;
      report_mode   <= MODE_DIST;
      capture_phase <= PH_IDLE;
      start_stamp   <= 16'd0;
      sample_slot   <= 2'd0;
      measurement   <= 16'd0;
      last_reported <= 16'd0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_BOTTOM: bottom_level <= cfg_data;
          CFG_TOP:    top_level    <= cfg_data;
          CFG_MODE:   report_mode  <= cfg_data[0];
          default:    ;
        endcase
      end

      // Output register: load a finished report, or drop an accepted one.
      if ((state == S_OUT) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            case (func)
              FUNC_TRIGGER: capture_phase <= PH_ARMED;
              FUNC_EDGE: begin
                if (capture_phase == PH_ARMED) begin
                  start_stamp   <= capture_time;
                  capture_phase <= PH_WAIT;
                end else if (capture_phase == PH_WAIT) begin
                  pulse_widths[sample_slot] <= width_val;
                  capture_phase <= PH_IDLE;
                  sample_slot   <= sample_slot + 2'd1;
                  if (sample_slot == 2'd3) begin
                    scan_idx <= 2'd0;
                    scan_sum <= 18'd0;
                    state    <= S_SCAN;
                  end
                end
              end
              FUNC_TICK: begin
                quo       <= {8'd0, dist_prod};
                rem       <= 16'd0;
                divisor   <= DIST_DIV;
                div_count <= '0;
                pct_pass  <= 1'b0;
                state     <= S_DIV;
              end
              default: ;
            endcase
          end
        end

        S_SCAN: begin
          scan_sum <= scan_sum + {2'd0, scan_word};
          if ((scan_idx == 2'd0) || (scan_word >= scan_max)) begin
            scan_max <= scan_word;
          end
          if ((scan_idx == 2'd0) || (scan_word <= scan_min)) begin
            scan_min <= scan_word;
          end
          scan_idx <= scan_idx + 2'd1;
          if (scan_idx == 2'd3) begin
            state <= S_MEAN;
          end
        end

        S_MEAN: begin
          measurement <= trim_sum[16:1];
          state       <= S_CHECK;
        end

        S_CHECK: begin
          if (delta > CHANGE_LIMIT) begin
            last_reported <= measurement;
            quo       <= {8'd0, dist_prod};
            rem       <= 16'd0;
            divisor   <= DIST_DIV;
            div_count <= '0;
            pct_pass  <= 1'b0;
            state     <= S_DIV;
          end else begin
            state <= S_IDLE;
          end
        end

        S_DIV: begin
          quo       <= quo_step;
          rem       <= r2s[15:0];
          div_count <= div_count + 1'b1;
          if (div_count == STEP_W'(DIV_STEPS - 1)) begin
            if (pct_pass) begin
              res_kind  <= REPORT_PCT;
              res_value <= quo_step[15:0];
              state     <= S_OUT;
            end else if (report_mode == MODE_DIST) begin
              res_kind  <= REPORT_DIST;
              res_value <= dist_sat;
              state     <= S_OUT;
            end else if (in_range) begin
              dist_keep <= dist_sat;
              state     <= S_PCT_MUL;
            end else begin
              state <= S_IDLE;
            end
          end
        end

        S_PCT_MUL: begin
          quo       <= pct_prod;
          rem       <= 16'd0;
          divisor   <= top_level - bottom_level;
          div_count <= '0;
          pct_pass  <= 1'b1;
          state     <= S_DIV;
        end

        S_OUT: begin
          if (out_free) begin
            report_kind  <= res_kind;
            report_value <= res_value;
            state        <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // A percent report never reaches one hundred percent.
  a_pct_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (report_kind == REPORT_PCT)) |-> (report_value < 16'd10000))
    else $error("percent report out of range");

  // The partial remainder stays below the divisor while dividing.
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> ((rem < divisor) && (divisor != 16'd0)))
    else $error("divider remainder not below a nonzero divisor");

  // The scan visits all four widths before the mean is formed.
  a_scan_len: assert property (@(posedge clk) disable iff (rst)
    ((state == S_SCAN) && (scan_idx != 2'd3)) |=> (state == S_SCAN))
    else $error("width scan ended early");

  // A waiting report is not replaced by a new one.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    ((state == S_OUT) && out_valid && out_stall) |=> (state == S_OUT))
    else $error("report issued over a stalled one");

endmodule

>>> dv/echo_pulse_trimmed_mean_ranger_core_tb.sv
`timescale 1ns / 1ps

module echo_pulse_trimmed_mean_ranger_core_tb;
  import eptmr_pkg::*;

  // Codes that the package leaves unnamed.
  localparam logic [1:0] FUNC_SPARE = 2'd3;
  localparam logic [1:0] CFG_SPARE  = 2'd3;
  localparam logic       MODE_PCT   = 1'b1;

  // Scaling of a measurement into a distance and a percent value.
  localparam logic [31:0] DIST_NUM   = 32'd34;
  localparam logic [31:0] DIST_DEN   = 32'd25;
  localparam logic [31:0] DIST_SAT   = 32'hFFFF;
  localparam logic [31:0] PCT_FULL   = 32'd10000;
  localparam logic [15:0] MOVE_LIMIT = 16'd5;

  localparam int SETTLE_CYCLES  = 64;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int LONG_HOLD      = 400;
  localparam int PHASES         = 8;

  typedef struct packed {
    logic        kind;
    logic [15:0] value;
  } range_report_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = CFG_BOTTOM;
  logic [15:0] cfg_data = 16'd0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  func = FUNC_TRIGGER;
  logic [15:0] capture_time = 16'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        report_kind;
  logic [15:0] report_value;

  // Expected reports, oldest first.
  range_report_t pending_reports[$];

  // Mirror of the ranger state and its level registers.
  logic [1:0]  arm_phase = PH_IDLE;
  logic [15:0] echo_start = 16'd0;
  logic [15:0] widths [4] = '{default: 16'd0};
  logic [1:0]  width_slot = 2'd0;
  logic [15:0] avg_width = 16'd0;
  logic [15:0] last_sent_width = 16'd0;
  logic [15:0] lvl_bottom = 16'd0;
  logic [15:0] lvl_top = 16'hFFFF;
  logic        pct_mode = MODE_DIST;

  bit idling_on = 1'b1;
  int hold_request = 0;
  int mismatch_count = 0;
  int quiet_cycles = 0;
  int requests_sent = 0;
  int widths_done = 0;
  int ticks_sent = 0;
  int dist_reports = 0;
  int pct_reports = 0;
  int level_settings = 0;

  echo_pulse_trimmed_mean_ranger_core dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .func         (func),
    .capture_time (capture_time),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .report_kind  (report_kind),
    .report_value (report_value)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic flag_mismatch(string msg);
    mismatch_count++;
    $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  // Drop the last-found largest and smallest width and average the other two.
  function automatic logic [15:0] trimmed_width();
    int hi;
    int lo;
    int i;
    logic [16:0] sum;
    hi = 0;
    lo = 0;
    sum = '0;
    for (i = 1; i < 4; i++) begin
      if (widths[i] >= widths[hi]) hi = i;
      if (widths[i] <= widths[lo]) lo = i;
    end
    if (hi == lo) return widths[lo];
    for (i = 0; i < 4; i++) begin
      if (i != hi && i != lo) sum = sum + widths[i];
    end
    return sum[16:1];
  endfunction

  // Build the report for the current measurement; percent mode may give none.
  function automatic bit form_report(output range_report_t r);
    logic [31:0] dist_val;
    logic [31:0] pct;
    r = '0;
    dist_val = ({16'd0, avg_width} * DIST_NUM) / DIST_DEN;
    if (dist_val > DIST_SAT) dist_val = DIST_SAT;
    if (pct_mode == MODE_DIST) begin
      r.kind = REPORT_DIST;
      r.value = dist_val[15:0];
      return 1'b1;
    end
    if (dist_val > lvl_bottom && dist_val < lvl_top) begin
      pct = ((dist_val - lvl_bottom) * PCT_FULL) / (lvl_top - lvl_bottom);
      r.kind = REPORT_PCT;
      r.value = pct[15:0];
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Advance the mirror by one accepted request and queue any report it causes.
  function automatic void track_request(logic [1:0] f, logic [15:0] stamp);
    range_report_t r;
    logic [15:0] move;
    case (f)
      FUNC_TRIGGER: arm_phase = PH_ARMED;
      FUNC_TICK: begin
        if (form_report(r)) pending_reports.push_back(r);
      end
      FUNC_EDGE: begin
        if (arm_phase == PH_ARMED) begin
          echo_start = stamp;
          arm_phase = PH_WAIT;
        end else if (arm_phase == PH_WAIT) begin
          widths[width_slot] = stamp - echo_start;
          arm_phase = PH_IDLE;
          width_slot = width_slot + 2'd1;
          if (width_slot == 2'd0) begin
            avg_width = trimmed_width();
            move = (avg_width > last_sent_width) ? avg_width - last_sent_width
                                                 : last_sent_width - avg_width;
            if (move > MOVE_LIMIT) begin
              last_sent_width = avg_width;
              if (form_report(r)) pending_reports.push_back(r);
            end
          end
        end
      end
      default: ;
    endcase
  endfunction

  // Offer one request, with an optional gap first, and wait until it is taken.
  task automatic send_request(logic [1:0] f, logic [15:0] stamp);
    int gap;
    if (idling_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 17);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= f;
    capture_time <= stamp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    track_request(f, stamp);
    requests_sent++;
    if (f == FUNC_TICK) ticks_sent++;
  endtask

  // One echo: arm, stamp the start, stamp the end.
  task automatic run_width(logic [15:0] w);
    logic [15:0] t0;
    t0 = 16'($urandom);
    send_request(FUNC_TRIGGER, 16'($urandom));
    send_request(FUNC_EDGE, t0);
    send_request(FUNC_EDGE, t0 + w);
    widths_done++;
  endtask

  task automatic measure_set(logic [15:0] w0, logic [15:0] w1, logic [15:0] w2,
                             logic [15:0] w3);
    run_width(w0);
    run_width(w1);
    run_width(w2);
    run_width(w3);
  endtask

  // Stop offering, wait for every expected report, then let the block settle.
  task automatic wait_reports_drained();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write; the caller lowers the write enable after its last write.
  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      CFG_BOTTOM: lvl_bottom = data;
      CFG_TOP:    lvl_top = data;
      CFG_MODE:   pct_mode = data[0];
      default: ;
    endcase
  endtask

  task automatic program_levels(logic [15:0] b, logic [15:0] t, logic mode);
    logic [15:0] mode_word;
    mode_word = 16'($urandom);
    mode_word[0] = mode;
    wait_reports_drained();
    write_reg(CFG_BOTTOM, b);
    write_reg(CFG_TOP, t);
    write_reg(CFG_MODE, mode_word);
    if ($urandom_range(0, 1) == 0) write_reg(CFG_SPARE, 16'($urandom));
    cfg_write <= 1'b0;
    level_settings++;
  endtask

  // Tick at reset, ignored requests, re-arming, timer wrap, zero and full widths.
  task automatic test_directed_capture();
    send_request(FUNC_TICK, 16'hFFFF);
    send_request(FUNC_EDGE, 16'h1111);
    send_request(FUNC_SPARE, 16'hFFFF);
    send_request(FUNC_TRIGGER, 16'h0000);
    send_request(FUNC_TRIGGER, 16'hA5A5);
    send_request(FUNC_EDGE, 16'hFFF0);
    send_request(FUNC_TRIGGER, 16'h5A5A);
    send_request(FUNC_EDGE, 16'hFFF0);
    send_request(FUNC_EDGE, 16'h0010);
    send_request(FUNC_TRIGGER, 16'h0000);
    send_request(FUNC_EDGE, 16'h0001);
    send_request(FUNC_EDGE, 16'h0000);
    send_request(FUNC_TRIGGER, 16'h0000);
    send_request(FUNC_EDGE, 16'h0005);
    send_request(FUNC_EDGE, 16'h0005);
    send_request(FUNC_TRIGGER, 16'h0000);
    send_request(FUNC_EDGE, 16'h1234);
    send_request(FUNC_EDGE, 16'h1254);
    send_request(FUNC_TICK, 16'h0000);
  endtask

  // Tied extremes that overflow 16 bits in the sum, then four equal widths.
  task automatic test_directed_trim();
    measure_set(16'hFFFF, 16'hFFFF, 16'hFFFE, 16'hFFFE);
    measure_set(16'd768, 16'd768, 16'd768, 16'd768);
  endtask

  // Percent mode at and around both levels, full range and inverted levels.
  task automatic test_directed_percent();
    program_levels(16'd1044, 16'd2000, MODE_PCT);
    send_request(FUNC_TICK, 16'($urandom));
    program_levels(16'd1043, 16'd1044, MODE_PCT);
    send_request(FUNC_TICK, 16'($urandom));
    program_levels(16'd1043, 16'd1045, MODE_PCT);
    send_request(FUNC_TICK, 16'($urandom));
    program_levels(16'd0, 16'hFFFF, MODE_PCT);
    send_request(FUNC_TICK, 16'($urandom));
    program_levels(16'd2000, 16'd100, MODE_PCT);
    send_request(FUNC_TICK, 16'($urandom));
  endtask

  // The receiver holds off for a long stretch while ticks keep coming.
  task automatic test_receiver_hold();
    program_levels(16'd0, 16'hFFFF, MODE_DIST);
    hold_request = LONG_HOLD;
    repeat (12) send_request(FUNC_TICK, 16'($urandom));
    wait_reports_drained();
  endtask

  // Mostly well-formed echoes around a drifting width, with ticks and noise.
  task automatic test_random_ranging(int phase, int n_requests);
    int base;
    int d0;
    int b;
    int t;
    int pick;
    int sent;
    logic [15:0] w;
    logic mode;
    mode = phase[0] ? MODE_PCT : MODE_DIST;
    base = (phase == 0) ? $urandom_range(40000, 65500) : $urandom_range(20, 30000);
    d0 = base * 34 / 25;
    if (d0 > 65535) d0 = 65535;
    if (phase == 1) begin
      b = 0;
      t = 65535;
    end else if (phase == 3) begin
      b = $urandom_range(30000, 65535);
      t = $urandom_range(0, b);
    end else begin
      b = d0 - $urandom_range(0, d0 / 2);
      t = d0 + $urandom_range(1, 4000);
      if (t > 65535) t = 65535;
    end
    program_levels(16'(b), 16'(t), mode);
    idling_on = (phase != PHASES - 1);
    sent = 0;
    while (sent < n_requests) begin
      if (phase != PHASES - 1 && $urandom_range(0, 11) == 0) begin
        idling_on = ($urandom_range(0, 3) != 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 72) begin
        if ($urandom_range(0, 7) == 0) begin
          base = base + $urandom_range(0, 400) - 200;
          if (base < 0) base = 0;
          if (base > 65500) base = 65500;
        end
        w = 16'(base + $urandom_range(0, 12));
        if (pick < 2) w = 16'($urandom);
        run_width(w);
        sent += 3;
      end else if (pick < 86) begin
        send_request(FUNC_TICK, 16'($urandom));
        sent++;
      end else if (pick < 92) begin
        // Broken echo: armed and started, then left for the next trigger.
        send_request(FUNC_TRIGGER, 16'($urandom));
        send_request(FUNC_EDGE, 16'($urandom));
        sent += 2;
      end else begin
        send_request(2'($urandom_range(0, 3)), 16'($urandom));
      end
    end
  endtask

  // Report sink: random stall bursts, plus the long hold-off when asked.
  initial begin : report_sink
    int burst;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        burst = hold_request;
        hold_request = 0;
        out_stall <= 1'b1;
        repeat (burst) @(posedge clk);
        out_stall <= 1'b0;
      end else if (idling_on && $urandom_range(0, 4) == 0) begin
        burst = $urandom_range(1, 17);
        out_stall <= 1'b1;
        repeat (burst) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Compare each accepted report with the oldest expectation.
  always @(posedge clk) begin
    range_report_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_reports.size() == 0) begin
        flag_mismatch($sformatf("unexpected report kind %0b value %0d",
                                report_kind, report_value));
      end else begin
        want = pending_reports.pop_front();
        if (report_kind !== want.kind) begin
          flag_mismatch($sformatf("report_kind %0b, expected %0b", report_kind, want.kind));
        end
        if (report_value !== want.value) begin
          flag_mismatch($sformatf("report_value %0d, expected %0d",
                                  report_value, want.value));
        end
        if (want.kind == REPORT_PCT) pct_reports++;
        else dist_reports++;
      end
    end
  end

  // Watchdog on cycles in which neither channel moves.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no request or report moved for %0d cycles", WATCHDOG_LIMIT);
      $display("echo_pulse_trimmed_mean_ranger_core verification failed");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_capture();
    test_directed_trim();
    test_directed_percent();
    test_receiver_hold();
    for (int p = 0; p < PHASES; p++) begin
      test_random_ranging(p, 130);
    end
    wait_reports_drained();
    $display("Sent %0d requests (%0d echo widths, %0d ticks) over %0d level settings.",
             requests_sent, widths_done, ticks_sent, level_settings);
    $display("Checked %0d distance and %0d percent reports, including a long hold-off.",
             dist_reports, pct_reports);
    if (mismatch_count == 0) begin
      $display("echo_pulse_trimmed_mean_ranger_core verification clean");
    end else begin
      $display("echo_pulse_trimmed_mean_ranger_core verification failed");
    end
    $finish;
  end

endmodule

>>> echo_pulse_trimmed_mean_ranger_core.f
design/eptmr_pkg.sv
design/echo_pulse_trimmed_mean_ranger_core.sv
dv/echo_pulse_trimmed_mean_ranger_core_tb.sv
